>>> rtl/isaac64_pkg.sv
// shared types and constants for the isaac64 generator
// depends on nothing; used by isaac64_ctrl, isaac64_dp and the top level
package isaac64_pkg;

	localparam int LOG_SIZE = 8;
	localparam int DEPTH    = 1 << LOG_SIZE;
	localparam int HALF     = DEPTH / 2;
	localparam int ADDR_W   = LOG_SIZE;
	localparam int WORD_W   = 64;
	localparam logic [WORD_W-1:0] GOLDEN = 64'h9e3779b97f4a7c13;

	typedef logic [1:0] func_t;
	localparam func_t FUNC_SEED = 2'd0;
	localparam func_t FUNC_INIT = 2'd1;
	localparam func_t FUNC_NEXT = 2'd2;

	typedef logic [7:0][WORD_W-1:0] lanes_t;

	typedef enum logic [3:0] {
		DP_NOP, DP_SEED, DP_CLR, DP_SCR, DP_ADD_RD, DP_ADD, DP_WR_MIX,
		DP_RG_START, DP_RG0, DP_RG1, DP_RG2, DP_RG3, DP_FRD, DP_FOUT
	} dp_op_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_ICLR, ST_ISCR, ST_PRD, ST_PADD, ST_PSCR, ST_PWR,
		ST_RGS, ST_RG0, ST_RG1, ST_RG2, ST_RG3, ST_FRD, ST_FOUT
	} state_t;

	typedef struct packed {
		dp_op_t            op;
		logic [ADDR_W-1:0] idx;
		logic [2:0]        line;
		logic              sel;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage

>>> rtl/isaac64_ctrl.sv
// sequencer for seeding, regeneration and fetch of the isaac64 generator
// depends on isaac64_pkg; drives isaac64_dp through command and status structs
module isaac64_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  isaac64_pkg::func_t      func,
	input  logic                    full_seed,
	input  isaac64_pkg::dp_status_t status,
	output logic                    in_ready,
	output isaac64_pkg::dp_cmd_t    cmd
);

	isaac64_pkg::state_t state_q, state_n;
	logic [isaac64_pkg::ADDR_W-1:0] idx_q, pos_q;
	logic [2:0] line_q;
	logic [1:0] cnt_q;
	logic pass_q, full_q;
	logic accept;

	assign accept = (state_q == isaac64_pkg::ST_IDLE) && in_valid;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			isaac64_pkg::ST_IDLE: begin
				if (in_valid && func == isaac64_pkg::FUNC_INIT) state_n = isaac64_pkg::ST_ICLR;
				else if (in_valid && func == isaac64_pkg::FUNC_NEXT) state_n = isaac64_pkg::ST_FRD;
			end
			isaac64_pkg::ST_ICLR: state_n = isaac64_pkg::ST_ISCR;
			isaac64_pkg::ST_ISCR: begin
				if (line_q == 3'd7 && cnt_q == 2'd3)
					state_n = full_q ? isaac64_pkg::ST_PRD : isaac64_pkg::ST_PSCR;
			end
			isaac64_pkg::ST_PRD: state_n = isaac64_pkg::ST_PADD;
			isaac64_pkg::ST_PADD: begin
				state_n = (idx_q[2:0] == 3'd7) ? isaac64_pkg::ST_PSCR : isaac64_pkg::ST_PRD;
			end
			isaac64_pkg::ST_PSCR: begin
				if (line_q == 3'd7) state_n = isaac64_pkg::ST_PWR;
			end
			isaac64_pkg::ST_PWR: begin
				if (idx_q[2:0] == 3'd7) begin
					if (idx_q == '1)
						state_n = (!pass_q && full_q) ? isaac64_pkg::ST_PRD
						                              : isaac64_pkg::ST_RGS;
					else
						state_n = full_q ? isaac64_pkg::ST_PRD : isaac64_pkg::ST_PSCR;
				end
			end
			isaac64_pkg::ST_RGS: state_n = isaac64_pkg::ST_RG0;
			isaac64_pkg::ST_RG0: state_n = isaac64_pkg::ST_RG1;
			isaac64_pkg::ST_RG1: state_n = isaac64_pkg::ST_RG2;
			isaac64_pkg::ST_RG2: state_n = isaac64_pkg::ST_RG3;
			isaac64_pkg::ST_RG3: begin
				state_n = (idx_q == '1) ? isaac64_pkg::ST_IDLE : isaac64_pkg::ST_RG0;
			end
			isaac64_pkg::ST_FRD: state_n = isaac64_pkg::ST_FOUT;
			isaac64_pkg::ST_FOUT: begin
				if (status.out_free)
					state_n = (pos_q == '1) ? isaac64_pkg::ST_RGS : isaac64_pkg::ST_IDLE;
			end
			default: state_n = isaac64_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd.op   = isaac64_pkg::DP_NOP;
		cmd.idx  = idx_q;
		cmd.line = line_q;
		cmd.sel  = pass_q;
		unique case (state_q)
			isaac64_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && func == isaac64_pkg::FUNC_SEED) cmd.op = isaac64_pkg::DP_SEED;
			end
			isaac64_pkg::ST_ICLR: cmd.op = isaac64_pkg::DP_CLR;
			isaac64_pkg::ST_ISCR: cmd.op = isaac64_pkg::DP_SCR;
			isaac64_pkg::ST_PRD:  cmd.op = isaac64_pkg::DP_ADD_RD;
			isaac64_pkg::ST_PADD: cmd.op = isaac64_pkg::DP_ADD;
			isaac64_pkg::ST_PSCR: cmd.op = isaac64_pkg::DP_SCR;
			isaac64_pkg::ST_PWR:  cmd.op = isaac64_pkg::DP_WR_MIX;
			isaac64_pkg::ST_RGS:  cmd.op = isaac64_pkg::DP_RG_START;
			isaac64_pkg::ST_RG0:  cmd.op = isaac64_pkg::DP_RG0;
			isaac64_pkg::ST_RG1:  cmd.op = isaac64_pkg::DP_RG1;
			isaac64_pkg::ST_RG2:  cmd.op = isaac64_pkg::DP_RG2;
			isaac64_pkg::ST_RG3:  cmd.op = isaac64_pkg::DP_RG3;
			isaac64_pkg::ST_FRD: begin
				cmd.op  = isaac64_pkg::DP_FRD;
				cmd.idx = pos_q;
			end
			isaac64_pkg::ST_FOUT: begin
				if (status.out_free) cmd.op = isaac64_pkg::DP_FOUT;
			end
			default: cmd.op = isaac64_pkg::DP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= isaac64_pkg::ST_IDLE;
			idx_q   <= '0;
			pos_q   <= '0;
			line_q  <= '0;
			cnt_q   <= '0;
			pass_q  <= 1'b0;
			full_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			if (accept && func == isaac64_pkg::FUNC_INIT) full_q <= full_seed;
			case (state_q)
				isaac64_pkg::ST_ICLR: begin
					line_q <= '0;
					cnt_q  <= '0;
				end
				isaac64_pkg::ST_ISCR: begin
					line_q <= line_q + 3'd1;
					if (line_q == 3'd7) cnt_q <= cnt_q + 2'd1;
					if (line_q == 3'd7 && cnt_q == 2'd3) begin
						idx_q  <= '0;
						pass_q <= 1'b0;
					end
				end
				isaac64_pkg::ST_PADD: begin
					if (idx_q[2:0] == 3'd7) idx_q <= idx_q - isaac64_pkg::ADDR_W'(7);
					else idx_q <= idx_q + 1'b1;
				end
				isaac64_pkg::ST_PSCR: line_q <= line_q + 3'd1;
				isaac64_pkg::ST_PWR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == '1 && !pass_q && full_q) pass_q <= 1'b1;
				end
				isaac64_pkg::ST_RGS: idx_q <= '0;
				isaac64_pkg::ST_RG3: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == '1) pos_q <= '0;
				end
				isaac64_pkg::ST_FOUT: begin
					if (status.out_free) pos_q <= pos_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	a_regen_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == isaac64_pkg::ST_RG3 && idx_q == '1) |=> state_q == isaac64_pkg::ST_IDLE)
		else $error("regeneration did not return to idle");
	a_add_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == isaac64_pkg::ST_PADD |-> $past(state_q) == isaac64_pkg::ST_PRD)
		else $error("seed add without a read");
	a_init_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && func == isaac64_pkg::FUNC_INIT) |=> state_q == isaac64_pkg::ST_ICLR)
		else $error("initialize transfer not started");

endmodule

>>> rtl/isaac64_dp.sv
// datapath of the isaac64 generator: lanes, accumulators, both memories
// depends on isaac64_pkg; commanded by isaac64_ctrl
module isaac64_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  isaac64_pkg::dp_cmd_t                 cmd,
	input  logic [7:0]                           seed_index,
	input  logic [isaac64_pkg::WORD_W-1:0]       seed_word,
	input  logic                                 out_ready,
	output isaac64_pkg::dp_status_t              status,
	output logic                                 out_valid,
	output logic [isaac64_pkg::WORD_W-1:0]       out_word
);

	localparam int AW = isaac64_pkg::ADDR_W;
	localparam int WW = isaac64_pkg::WORD_W;
	localparam int LS = isaac64_pkg::LOG_SIZE;

	logic [WW-1:0] mix_mem [isaac64_pkg::DEPTH];
	logic [WW-1:0] res_mem [isaac64_pkg::DEPTH];
	logic [isaac64_pkg::DEPTH-1:0] mix_vld_q, res_vld_q;

	isaac64_pkg::lanes_t v_q;
	logic [WW-1:0] a_q, b_q, rc_q, x_q, mrd0_q, mrd1_q, rrd_q, out_q;
	logic out_vld_q;

	logic mwe, rwe, rre;
	logic [AW-1:0] mwa, mra0, mra1, rwa, rra;
	logic [WW-1:0] mwd, rwd, y, rc_n;

	function automatic isaac64_pkg::lanes_t scr_line(isaac64_pkg::lanes_t v, logic [2:0] j);
		isaac64_pkg::lanes_t r;
		logic [2:0] p, q, t;
		logic [WW-1:0] sh;
		r = v;
		p = j + 3'd4;
		q = j + 3'd5;
		t = j + 3'd7;
		r[j] = v[j] - v[p];
		case (j)
			3'd0: sh = v[t] >> 9;
			3'd1: sh = v[t] << 9;
			3'd2: sh = v[t] >> 23;
			3'd3: sh = v[t] << 15;
			3'd4: sh = v[t] >> 14;
			3'd5: sh = v[t] << 20;
			3'd6: sh = v[t] >> 17;
			default: sh = v[t] << 14;
		endcase
		r[q] = v[q] ^ sh;
		r[t] = v[t] + r[j];
		return r;
	endfunction

	function automatic logic [WW-1:0] a_mix(logic [WW-1:0] a, logic [1:0] ph);
		logic [WW-1:0] s;
		case (ph)
			2'd0: s = ~(a ^ (a << 21));
			2'd1: s = a ^ (a >> 5);
			2'd2: s = a ^ (a << 12);
			default: s = a ^ (a >> 33);
		endcase
		return s;
	endfunction

	assign y    = mrd0_q + a_q + b_q;
	assign rc_n = rc_q + 1'b1;

	always_comb begin
		mwe  = 1'b0;
		mwa  = cmd.idx;
		mwd  = v_q[cmd.idx[2:0]];
		mra0 = cmd.idx;
		mra1 = cmd.idx + AW'(isaac64_pkg::HALF);
		rwe  = 1'b0;
		rwa  = cmd.idx;
		rwd  = mrd0_q + x_q;
		rre  = 1'b0;
		rra  = cmd.idx;
		case (cmd.op)
			isaac64_pkg::DP_SEED: begin
				rwe = 1'b1;
				rwa = seed_index[AW-1:0];
				rwd = seed_word;
			end
			isaac64_pkg::DP_ADD_RD: rre = 1'b1;
			isaac64_pkg::DP_FRD:    rre = 1'b1;
			isaac64_pkg::DP_WR_MIX: mwe = 1'b1;
			isaac64_pkg::DP_RG1:    mra0 = mrd0_q[LS+2:3];
			isaac64_pkg::DP_RG2: begin
				mwe  = 1'b1;
				mwd  = y;
				mra0 = y[2*LS+2:LS+3];
			end
			isaac64_pkg::DP_RG3:    rwe = 1'b1;
			default: ;
		endcase
	end

	// memories: registered reads, write-first on the lookup port
	always_ff @(posedge clk) begin
		if (mwe) mix_mem[mwa] <= mwd;
		if (rwe) res_mem[rwa] <= rwd;
		if (mwe && mwa == mra0) mrd0_q <= mwd;
		else mrd0_q <= mix_vld_q[mra0] ? mix_mem[mra0] : '0;
		mrd1_q <= mix_vld_q[mra1] ? mix_mem[mra1] : '0;
		if (rre) rrd_q <= res_vld_q[rra] ? res_mem[rra] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mix_vld_q <= '0;
			res_vld_q <= '0;
		end else begin
			if (mwe) mix_vld_q[mwa] <= 1'b1;
			if (rwe) res_vld_q[rwa] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q       <= '0;
			b_q       <= '0;
			rc_q      <= '0;
			out_vld_q <= 1'b0;
		end else begin
			case (cmd.op)
				isaac64_pkg::DP_CLR: begin
					a_q  <= '0;
					b_q  <= '0;
					rc_q <= '0;
				end
				isaac64_pkg::DP_RG_START: begin
					rc_q <= rc_n;
					b_q  <= b_q + rc_n;
				end
				isaac64_pkg::DP_RG1: a_q <= a_mix(a_q, cmd.idx[1:0]) + mrd1_q;
				isaac64_pkg::DP_RG3: b_q <= rwd;
				default: ;
			endcase
			if (cmd.op == isaac64_pkg::DP_FOUT) out_vld_q <= 1'b1;
			else if (out_ready) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			isaac64_pkg::DP_CLR: v_q <= {8{isaac64_pkg::GOLDEN}};
			isaac64_pkg::DP_SCR: v_q <= scr_line(v_q, cmd.line);
			isaac64_pkg::DP_ADD: begin
				v_q[cmd.idx[2:0]] <= v_q[cmd.idx[2:0]] + (cmd.sel ? mrd0_q : rrd_q);
			end
			isaac64_pkg::DP_RG1:  x_q   <= mrd0_q;
			isaac64_pkg::DP_FOUT: out_q <= rrd_q;
			default: ;
		endcase
	end

	assign status.out_free = !out_vld_q || out_ready;
	assign out_valid       = out_vld_q;
	assign out_word        = out_q;

endmodule

>>> rtl/isaac64_random_generator.sv
// isaac64 pseudo-random generator, top level
// depends on isaac64_pkg, isaac64_ctrl and isaac64_dp
//
// input channel s_*: tuser carries the function code (0 seed write,
// 1 initialize, 2 fetch, 3 ignored); tdata carries seed index, seed word
// and the full-seed flag. output channel m_*: one 64-bit word per fetch.
// a seed write completes in its transfer cycle. an initialize runs start
// mixing (32 scramble steps), then one pass (two with the full-seed flag)
// of 32 blocks, each of read-add (8 words, only with the flag), scramble
// (8 lines) and writeback (8 words), then a regeneration of all 256 words,
// bound by the lookup port of the mixing memory. a fetch reads the result
// memory into the output register; every 256th fetch adds a regeneration
// before the next transfer is taken. a fetch result waits in the output
// register while m_tready is low; the block takes the next transfer
// meanwhile but holds a later fetch until the register is free. after reset
// both memories read as zero and the control state clears; lanes and data are not reset.
module isaac64_random_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // seed_index, seed_word, init_full_seed, zero pad
	input  logic [1:0]  s_tuser,   // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata    // random_word
);

	isaac64_pkg::dp_cmd_t    cmd;
	isaac64_pkg::dp_status_t status;

	isaac64_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.func      (s_tuser),
		.full_seed (s_tdata[72]),
		.status    (status),
		.in_ready  (s_tready),
		.cmd       (cmd)
	);

	isaac64_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.seed_index (s_tdata[7:0]),
		.seed_word  (s_tdata[71:8]),
		.out_ready  (m_tready),
		.status     (status),
		.out_valid  (m_tvalid),
		.out_word   (m_tdata)
	);

endmodule
